[sv/tpcm_pkg.sv]
// ----------------------------------------------------------------------------
// tpcm_pkg
// Shared types and constants for the thermal pseudo-color mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [1:0] CFG_BOTTOM_TEMP  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_WIDTH = 2'd2;

    // Color modes.
    localparam logic [1:0] MODE_GRAY  = 2'd0;
    localparam logic [1:0] MODE_PAL4  = 2'd1;
    localparam logic [1:0] MODE_PAL16 = 2'd2;

    // Pixel kinds carried in tuser.
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_MAP     = 1'b1;

    localparam logic [15:0] RAW_MIN_RESET = 16'hFFFF;
    localparam logic [15:0] RAW_MAX_RESET = 16'h0000;

    // ceil(2^24 / 100); exact division by 100 for dividends below 2^17.
    localparam logic [17:0] DIV100_RECIP = 18'd167773;

    // Queue entry: one map pixel with the statistics valid when it arrived.
    typedef struct packed {
        logic [15:0] raw;
        logic [15:0] min_raw;
        logic [15:0] max_raw;
        logic        last;
    } t_entry;

    // One color channel: add + num / den, clamped to 0..255.
    typedef struct packed {
        logic [24:0] num;
        logic [16:0] den;
        logic [8:0]  add;
    } t_spec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GO,
        ST_WAIT,
        ST_GRAYCHK,
        ST_SETUP,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        STEP_DISP,
        STEP_RED,
        STEP_GREEN,
        STEP_BLUE
    } t_step;

endpackage

`default_nettype wire

[sv/tpcm_fifo.sv]
// ----------------------------------------------------------------------------
// tpcm_fifo
// Four-entry queue between the pixel front end and the color engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcm_fifo
    import tpcm_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_entry i_entry,
    input  wire    i_pop,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    t_entry     r_mem [0:3];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 2'd1;
            if (i_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);

endmodule

`default_nettype wire

[sv/tpcm_front.sv]
// ----------------------------------------------------------------------------
// tpcm_front
// Accepts pixels, keeps the frame's min/max and queues map pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcm_front
    import tpcm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire  [15:0] i_raw,
    input  wire         i_func,
    input  wire         i_last,
    output logic        o_ready,
    input  wire         i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [15:0] r_min;
    logic [15:0] r_max;
    logic        w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc && (i_func == FUNC_MAP);

    assign o_entry.raw     = i_raw;
    assign o_entry.min_raw = r_min;
    assign o_entry.max_raw = r_max;
    assign o_entry.last    = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RAW_MIN_RESET;
            r_max <= RAW_MAX_RESET;
        end else if (w_acc) begin
            if (i_func == FUNC_MEASURE) begin
                if (i_raw < r_min) r_min <= i_raw;
                if (i_raw > r_max) r_max <= i_raw;
            end else if (i_last) begin
                // The last map pixel of a frame restarts the statistics.
                r_min <= RAW_MIN_RESET;
                r_max <= RAW_MAX_RESET;
            end
        end
    end

endmodule

`default_nettype wire

[sv/tpcm_div.sv]
// ----------------------------------------------------------------------------
// tpcm_div
// Restoring divider, one quotient bit per cycle, 25-bit by 17-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcm_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [24:0] i_num,
    input  wire  [16:0] i_den,
    output logic        o_done,
    output logic [24:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [24:0] r_num;
    logic [16:0] r_rem;
    logic [16:0] r_den;
    logic [17:0] w_sh;
    logic        w_ge;
    logic [17:0] w_diff;

    always_comb begin
        w_sh   = {r_rem, r_num[24]};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[23:0], w_ge};
            r_rem <= w_ge ? w_diff[16:0] : w_sh[16:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

`default_nettype wire

[sv/tpcm_back.sv]
// ----------------------------------------------------------------------------
// tpcm_back
// Color engine: gray scaling and palette lookup through a shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcm_back
    import tpcm_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire   [1:0]  i_color_mode,
    input  wire   [16:0] i_bottom_temp,
    input  wire   [7:0]  i_window_width,
    input  wire          i_empty,
    input  t_entry       i_head,
    output logic         o_pop,
    output logic         o_valid,
    input  wire          i_ready,
    output logic  [31:0] o_data,
    output logic         o_last
);

    t_state      r_state;
    t_state      n_state;
    t_step       r_step;
    t_step       n_step;
    t_entry      r_ent;
    logic [7:0]  r_disp;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_gray;
    t_spec       r_spec_r;
    t_spec       r_spec_g;
    t_spec       r_spec_b;
    logic        r_ov;
    logic [31:0] r_odata;
    logic        r_olast;

    logic        w_start;
    logic        w_done;
    logic [24:0] w_quo;
    logic [24:0] w_num;
    logic [16:0] w_den;
    logic        w_emit;
    logic        w_zero_range;
    logic [15:0] w_v;
    logic signed [19:0] w_sg;
    logic [34:0] w_gprod;
    logic [10:0] w_gquo;
    logic [7:0]  w_gray;
    logic [7:0]  w_chan;
    t_spec       w_cur;
    t_spec       w_sr;
    t_spec       w_sg_spec;
    t_spec       w_sb;
    logic        w_color_on;

    function automatic t_spec mk(input logic [21:0] x, input logic [8:0] k,
                                 input logic [16:0] den, input logic [8:0] add);
        t_spec       sp;
        logic [30:0] p;
        p      = 31'(x) * 31'(k);
        sp.num = p[24:0];
        sp.den = den;
        sp.add = add;
        return sp;
    endfunction

    function automatic t_spec cst(input logic [8:0] add);
        t_spec sp;
        sp.num = '0;
        sp.den = 17'd1;
        sp.add = add;
        return sp;
    endfunction

    function automatic logic [7:0] sat8(input logic [8:0] add, input logic [24:0] q);
        logic [9:0] sum;
        sum = {1'b0, add} + {2'b0, q[7:0]};
        if (q > 25'd255 || sum > 10'd255) return 8'd255;
        return sum[7:0];
    endfunction

    tpcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    // Gray path. The division by 100 is a reciprocal multiplication; it is
    // only used when the sum is at least 100, so the low 17 bits hold it.
    always_comb begin
        w_zero_range = (r_ent.max_raw <= r_ent.min_raw);
        w_v = r_ent.raw;
        if (w_v < r_ent.min_raw) w_v = r_ent.min_raw;
        if (w_v > r_ent.max_raw) w_v = r_ent.max_raw;
        w_sg = $signed({{3{i_bottom_temp[16]}}, i_bottom_temp}) - 20'sd2200
             + $signed({5'b0, 15'(r_disp) * 15'd100});
        w_gprod = {18'b0, w_sg[16:0]} * {17'b0, DIV100_RECIP};
        w_gquo  = w_gprod[34:24];
        w_gray  = (w_gquo > 11'd255) ? 8'd255 : w_gquo[7:0];
    end

    // Palette segment selection and per-channel ramp setup.
    always_comb begin
        logic signed [18:0] d;
        logic [16:0] s;
        logic [16:0] s2;
        logic [16:0] s3;
        logic [16:0] s5;
        logic [21:0] e;
        logic [21:0] q;
        logic [21:0] ks [0:16];
        d  = $signed({3'b0, r_ent.raw}) - 19'sd10000
           - $signed({{2{i_bottom_temp[16]}}, i_bottom_temp});
        s  = 17'(i_window_width) * 17'd100;
        s2 = s * 17'd2;
        s3 = s * 17'd3;
        s5 = s * 17'd5;
        e  = {1'b0, d[16:0], 4'b0};
        q  = {3'b0, d[16:0], 2'b0};
        for (int k = 0; k <= 16; k++) ks[k] = 22'(s) * 22'(k);
        w_sr      = cst(9'd0);
        w_sg_spec = cst(9'd0);
        w_sb      = cst(9'd0);
        if (d < 0) begin
            w_sr = cst(9'd0);
        end else if (i_color_mode == MODE_PAL4) begin
            if (s == 17'd0 || q > ks[4]) begin
                w_sr = cst(9'd255); w_sg_spec = cst(9'd255); w_sb = cst(9'd255);
            end else if (q < ks[1]) begin
                w_sg_spec = mk(q, 9'd255, s, 9'd0); w_sb = cst(9'd255);
            end else if (q <= ks[2]) begin
                w_sg_spec = cst(9'd255); w_sb = mk(ks[2] - q, 9'd255, s, 9'd0);
            end else if (q <= ks[3]) begin
                w_sr = mk(q - ks[2], 9'd255, s, 9'd0); w_sg_spec = cst(9'd255);
            end else begin
                w_sr = cst(9'd255); w_sg_spec = mk(ks[4] - q, 9'd255, s, 9'd0);
            end
        end else begin
            priority if (s == 17'd0 || e > ks[16]) begin
                w_sr = cst(9'd252); w_sg_spec = cst(9'd252); w_sb = cst(9'd252);
            end else if ({e[20:0], 1'b0} < ks[3]) begin
                w_sr = mk(e, 9'd168, s3, 9'd0); w_sg_spec = w_sr; w_sb = w_sr;
            end else if (e <= ks[3]) begin
                w_sr = mk(ks[3] - e, 9'd168, s3, 9'd0); w_sg_spec = w_sr;
                w_sb = mk({e[20:0], 1'b0} - ks[3], 9'd252, s5, 9'd84);
            end else if (e <= ks[4]) begin
                w_sr = mk(e - ks[3], 9'd84, s, 9'd0); w_sg_spec = w_sr;
                w_sb = mk(e - ks[3], 9'd336, s5, 9'd84);
            end else if (e <= ks[6]) begin
                w_sr = mk(ks[6] - e, 9'd84, s2, 9'd0);
                w_sg_spec = mk(e - ks[4], 9'd84, s2, 9'd84);
                w_sb = mk(ks[6] - e, 9'd84, s2, 9'd168);
            end else if (e <= ks[8]) begin
                w_sr = mk(e - ks[6], 9'd84, s2, 9'd0);
                w_sg_spec = mk(e - ks[6], 9'd84, s2, 9'd168);
                w_sb = w_sg_spec;
            end else if (e <= ks[9]) begin
                w_sr = mk(ks[9] - e, 9'd84, s, 9'd0);
                w_sg_spec = mk(ks[9] - e, 9'd84, s, 9'd168);
                w_sb = mk(ks[9] - e, 9'd252, s, 9'd0);
            end else if (e <= ks[10]) begin
                w_sr = mk(e - ks[9], 9'd84, s, 9'd0);
                w_sg_spec = mk(e - ks[9], 9'd84, s, 9'd168);
                w_sb = w_sr;
            end else if (e <= ks[11]) begin
                w_sr = mk(e - ks[10], 9'd168, s, 9'd84);
                w_sg_spec = cst(9'd252); w_sb = cst(9'd84);
            end else if (e <= ks[12]) begin
                w_sr = mk(ks[12] - e, 9'd84, s, 9'd168);
                w_sg_spec = mk(ks[12] - e, 9'd168, s, 9'd84);
                w_sb = mk(ks[12] - e, 9'd84, s, 9'd0);
            end else if (e <= ks[13]) begin
                w_sr = mk(e - ks[12], 9'd84, s, 9'd168);
                w_sg_spec = cst(9'd84);
                w_sb = mk(e - ks[12], 9'd252, s, 9'd0);
            end else if (e <= ks[14]) begin
                w_sr = mk(ks[14] - e, 9'd84, s, 9'd168);
                w_sg_spec = mk(ks[14] - e, 9'd84, s, 9'd0);
                w_sb = w_sr;
            end else if (e <= ks[15]) begin
                w_sr = mk(e - ks[14], 9'd84, s, 9'd168);
                w_sg_spec = mk(e - ks[14], 9'd84, s, 9'd0);
                w_sb = mk(ks[15] - e, 9'd84, s, 9'd84);
            end else begin
                w_sr = cst(9'd252);
                w_sg_spec = mk(ks[16] - e, 9'd84, s, 9'd0);
                w_sb = w_sg_spec;
            end
        end
    end

    // Divider operand selection.
    always_comb begin
        w_color_on = (i_color_mode == MODE_PAL4) || (i_color_mode == MODE_PAL16);
        unique case (r_step)
            STEP_RED:   w_cur = r_spec_r;
            STEP_GREEN: w_cur = r_spec_g;
            default:    w_cur = r_spec_b;
        endcase
        unique case (r_step)
            STEP_DISP: begin
                w_num = 25'(24'(w_v - r_ent.min_raw) * 24'd255);
                w_den = {1'b0, r_ent.max_raw - r_ent.min_raw};
            end
            default: begin
                w_num = w_cur.num;
                w_den = w_cur.den;
            end
        endcase
        w_chan = sat8(w_cur.add, w_quo);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_pop   = 1'b0;
        w_start = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_step  = STEP_DISP;
                n_state = w_zero_range ? ST_EMIT : ST_GO;
            end
            ST_GO: begin
                w_start = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_done) begin
                    unique case (r_step)
                        STEP_DISP:  n_state = ST_GRAYCHK;
                        STEP_RED:   begin n_step = STEP_GREEN; n_state = ST_GO; end
                        STEP_GREEN: begin n_step = STEP_BLUE;  n_state = ST_GO; end
                        default:    n_state = ST_EMIT;
                    endcase
                end
            end
            ST_GRAYCHK: begin
                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_step  = STEP_RED;
                n_state = w_color_on ? ST_GO : ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ov || i_ready) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_DISP;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_emit)      r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent   <= i_head;
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_gray  <= '0;
        end
        if (r_state == ST_WAIT && w_done) begin
            unique case (r_step)
                STEP_DISP:  r_disp  <= w_quo[7:0];
                STEP_RED:   r_red   <= w_chan;
                STEP_GREEN: r_green <= w_chan;
                default:    r_blue  <= w_chan;
            endcase
        end
        // A gray sum below one whole step leaves the level at zero.
        if (r_state == ST_GRAYCHK && w_sg >= 20'sd100) begin
            r_gray <= w_gray;
        end
        if (r_state == ST_SETUP) begin
            r_spec_r <= w_sr;
            r_spec_g <= w_sg_spec;
            r_spec_b <= w_sb;
        end
        if (w_emit) begin
            r_odata <= {r_gray, r_blue, r_green, r_red};
            r_olast <= r_ent.last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

[sv/thermal_pseudo_color_mapper_top.sv]
// ----------------------------------------------------------------------------
// thermal_pseudo_color_mapper_top
// Two-pass thermal false-color mapper: range measure, then gray and palette.
// ----------------------------------------------------------------------------
// Pixels with tuser low are measure-pass pixels: they update the frame's
// minimum and maximum raw count and give no output transaction. Pixels with
// tuser high are map-pass pixels: each one is queued together with the
// statistics seen at its arrival and later yields one output transaction
// holding red, green, blue and a gray level; tlast on a map pixel is passed
// to the result and restarts the statistics. Pixels of either kind are taken
// one per cycle while the queue is not full. The engine pops queued map
// pixels when idle and uses a single shared restoring divider that is
// started, develops 25 quotient bits and signals done; the gray level
// divides by 100 through a reciprocal multiply. The engine does no division
// on a pixel when the range is empty, one range division in gray-only mode,
// and with a palette one range division and three color divisions, plus
// sequencing. The result is registered when the engine leaves its emit
// state, which waits while the output register still holds a result the
// sink has not taken. A four-entry queue lets pixels keep arriving while
// the engine works. Configuration is written through a plain write port by
// the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_pseudo_color_mapper_top
    import tpcm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Pixel input.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] raw
    input  wire  [0:0]  s_axis_tuser,   // [0] func
    input  wire         s_axis_tlast,
    // Color output.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] gray
    output logic        m_axis_tlast,   // frame_end
    // Configuration.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [16:0] i_cfg_wdata
);

    logic [1:0]  r_color_mode;
    logic [16:0] r_bottom_temp;
    logic [7:0]  r_window_width;

    t_entry w_push_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode   <= MODE_PAL16;
            r_bottom_temp  <= 17'd2200;
            r_window_width <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COLOR_MODE:   r_color_mode   <= i_cfg_wdata[1:0];
                CFG_BOTTOM_TEMP:  r_bottom_temp  <= i_cfg_wdata;
                CFG_WINDOW_WIDTH: r_window_width <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Front end: statistics and classification.
    tpcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_raw   (s_axis_tdata),
        .i_func  (s_axis_tuser[0]),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    tpcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back end: gray scaling and palette ramps.
    tpcm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_color_mode   (r_color_mode),
        .i_bottom_temp  (r_bottom_temp),
        .i_window_width (r_window_width),
        .i_empty        (w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata),
        .o_last         (m_axis_tlast)
    );

endmodule

`default_nettype wire
